@@ rtl/core/ata_task_file_builder_unit_defines.svh @@
// Assertion macros shared by the task-file builder RTL.
`ifndef ATA_TASK_FILE_BUILDER_UNIT_DEFINES_SVH
`define ATA_TASK_FILE_BUILDER_UNIT_DEFINES_SVH

// Condition must never hold once out of reset.
`define ATFB_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("task-file builder: forbidden condition seen");

// Antecedent in one cycle implies consequent in the next.
`define ATFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task-file builder: expected follow-up missing");

`endif

@@ rtl/core/atfb_pkg.sv @@
// Shared types and constants of the ATA task-file builder.
package atfb_pkg;

    localparam logic [7:0] OPC_READ_SECTORS  = 8'h20;
    localparam logic [7:0] OPC_WRITE_SECTORS = 8'h30;
    localparam logic [7:0] CTL_EIGHT     = 8'h08;
    localparam logic [7:0] LDH_RESET     = 8'hA0;
    localparam logic [4:0] HEADS_RESET   = 5'd16;
    localparam logic [7:0] SPT_RESET     = 8'd63;
    localparam logic [7:0] PRECOMP_RESET = 8'd0;
    localparam logic [4:0] HEADS_EIGHT   = 5'd8;
    localparam int         LDH_LBA_POS   = 6;

    localparam int BLOCK_W   = 28;
    localparam int PERCYL_W  = 13;              // 31 heads x 255 sectors fits
    localparam int HEAD_BITS = 5;
    localparam int CYL_STEPS = BLOCK_W / 2;     // two quotient bits per cycle
    localparam logic [3:0] CYL_LAST  = 4'(CYL_STEPS - 1);
    localparam logic [3:0] HEAD_LAST = 4'(HEAD_BITS - 1);

    typedef enum logic [1:0] {
        REG_LDH     = 2'd0,
        REG_HEADS   = 2'd1,
        REG_SPT     = 2'd2,
        REG_WPCOM   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] ldh;
        logic [4:0] heads;
        logic [7:0] spt;
        logic [7:0] precomp;
    } cfg_t;

    typedef struct packed {
        logic                lba;
        logic [BLOCK_W-1:0]  block;
        logic [PERCYL_W-1:0] per_cyl;
        logic [7:0]          spt;
        logic [7:0]          precomp;
        logic [7:0]          count;
        logic [7:0]          ldh;
        logic [7:0]          command;
        logic [7:0]          control;
    } job_t;

    typedef struct packed {
        logic [7:0] precomp;
        logic [7:0] count;
        logic [7:0] sector;
        logic [7:0] cyl_low;
        logic [7:0] cyl_high;
        logic [7:0] drive_head;
        logic [7:0] command;
        logic [7:0] control;
        logic       overflow;
    } result_t;

    typedef struct packed {
        logic pop_queue;
        logic cyl_step;
        logic head_step;
        logic res_load;
    } back_ctl_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_CYL  = 2'd1,
        BK_HEAD = 2'd2,
        BK_DONE = 2'd3
    } back_state_t;

endpackage

@@ rtl/core/atfb_front.sv @@
// Front end: takes requests, classifies LBA/CHS and prepares a job.
module atfb_front
    import atfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [27:0]  start_block,
    input  logic [8:0]   sector_count,
    input  logic         is_write,
    input  cfg_t         cfg,
    output logic         q_push,
    input  logic         q_full,
    output job_t         q_data
);

    logic       valid_reg, valid_next;
    job_t       job_reg, job_next;
    logic       accept;
    logic [4:0] heads_eff;
    logic [7:0] spt_eff;

    assign accept = push && !full;
    assign full   = valid_reg && q_full;
    assign q_push = valid_reg;
    assign q_data = job_reg;

    // zero geometry counts behave as one
    assign heads_eff = (cfg.heads == 5'd0) ? 5'd1 : cfg.heads;
    assign spt_eff   = (cfg.spt == 8'd0) ? 8'd1 : cfg.spt;

    always_comb
    begin
        job_next.lba     = cfg.ldh[LDH_LBA_POS];
        job_next.block   = start_block;
        job_next.per_cyl = PERCYL_W'({8'd0, heads_eff} * {5'd0, spt_eff});
        job_next.spt     = spt_eff;
        job_next.precomp = cfg.precomp;
        job_next.count   = sector_count[7:0];
        job_next.ldh     = cfg.ldh;
        job_next.command = is_write ? OPC_WRITE_SECTORS : OPC_READ_SECTORS;
        job_next.control = (cfg.heads >= HEADS_EIGHT) ? CTL_EIGHT : 8'd0;
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (q_push && !q_full)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

endmodule

@@ rtl/core/atfb_queue.sv @@
// Short job queue between front end and conversion engine.
module atfb_queue
    import atfb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  job_t data_in,
    input  logic pop,
    output logic empty,
    output job_t data_out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= data_in;
    end

endmodule

@@ rtl/core/atfb_back.sv @@
// Conversion engine: iterative CHS division and result register.
module atfb_back
    import atfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  job_t    q_data,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t res
);

    back_state_t         state_reg, state_next;
    back_ctl_t           ctl;
    job_t                job_reg;
    logic [BLOCK_W-1:0]  dvd_reg, dvd_next;
    logic [PERCYL_W-1:0] rem_reg, rem_cyl_next;
    logic [PERCYL_W-1:0] dsh_reg;
    logic [HEAD_BITS-1:0] hd_reg;
    logic [3:0]          step_reg;
    result_t             res_reg, res_next;
    logic                res_valid_reg, res_valid_next;
    logic                res_free;

    // two restoring-division steps per cycle
    logic [PERCYL_W:0]   t1, t2, r1, r2, dvs;
    logic                ge1, ge2, ge_h;

    assign res_free = !res_valid_reg || pop;
    assign empty    = !res_valid_reg;
    assign res      = res_reg;
    assign q_pop    = ctl.pop_queue;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_empty)
                    state_next = q_data.lba ? BK_DONE : BK_CYL;
            BK_CYL:
                if (step_reg == '0)
                    state_next = BK_HEAD;
            BK_HEAD:
                if (step_reg == '0)
                    state_next = BK_DONE;
            BK_DONE:
                if (res_free)
                    state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.pop_queue = (state_reg == BK_IDLE) && !q_empty;
        ctl.cyl_step  = (state_reg == BK_CYL);
        ctl.head_step = (state_reg == BK_HEAD);
        ctl.res_load  = (state_reg == BK_DONE) && res_free;
    end

    always_comb
    begin
        dvs = {1'b0, job_reg.per_cyl};
        t1  = {rem_reg, dvd_reg[BLOCK_W-1]};
        ge1 = (t1 >= dvs);
        r1  = ge1 ? t1 - dvs : t1;
        t2  = {r1[PERCYL_W-1:0], dvd_reg[BLOCK_W-2]};
        ge2 = (t2 >= dvs);
        r2  = ge2 ? t2 - dvs : t2;
        rem_cyl_next = r2[PERCYL_W-1:0];
        dvd_next     = {dvd_reg[BLOCK_W-3:0], ge1, ge2};
        ge_h         = (rem_reg >= dsh_reg);
    end

    always_comb
    begin
        res_next.precomp = job_reg.precomp;
        res_next.count   = job_reg.count;
        res_next.command = job_reg.command;
        res_next.control = job_reg.control;
        if (job_reg.lba)
        begin
            res_next.sector     = job_reg.block[7:0];
            res_next.cyl_low    = job_reg.block[15:8];
            res_next.cyl_high   = job_reg.block[23:16];
            res_next.drive_head = job_reg.ldh | {4'd0, job_reg.block[27:24]};
            res_next.overflow   = 1'b0;
        end
        else
        begin
            res_next.sector     = rem_reg[7:0] + 8'd1;
            res_next.cyl_low    = dvd_reg[7:0];
            res_next.cyl_high   = dvd_reg[15:8];
            res_next.drive_head = job_reg.ldh | {4'd0, hd_reg[3:0]};
            res_next.overflow   = |dvd_reg[BLOCK_W-1:16];
        end
    end

    always_comb
    begin
        if (ctl.res_load)
            res_valid_next = 1'b1;
        else if (pop)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pop_queue)
        begin
            job_reg  <= q_data;
            dvd_reg  <= q_data.block;
            rem_reg  <= '0;
            step_reg <= CYL_LAST;
        end
        if (ctl.cyl_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_cyl_next;
            if (step_reg == '0)
            begin
                step_reg <= HEAD_LAST;
                dsh_reg  <= PERCYL_W'({5'd0, job_reg.spt} << (HEAD_BITS - 1));
                hd_reg   <= '0;
            end
            else
                step_reg <= step_reg - 1'b1;
        end
        if (ctl.head_step)
        begin
            rem_reg  <= ge_h ? rem_reg - dsh_reg : rem_reg;
            dsh_reg  <= dsh_reg >> 1;
            hd_reg   <= {hd_reg[HEAD_BITS-2:0], ge_h};
            step_reg <= step_reg - 1'b1;
        end
        if (ctl.res_load)
            res_reg <= res_next;
    end

endmodule

@@ rtl/core/ata_task_file_builder_unit.sv @@
// Top level of the ATA task-file builder.
// Usage:
//  - Requests enter like a queue write: a transfer happens on a clock edge
//    with push high and full low (start_block, sector_count, is_write).
//  - Task-file bytes leave like a queue read: while empty is low the oldest
//    result sits on the result ports; pop high with empty low transfers it.
//  - Config writes (cfg_write, cfg_index, cfg_data) land at the clock edge
//    and must only be made with no request in flight.
//  - LBA mode (prefix bit 6): the engine skips the division and passes the
//    job straight on to the result register.
//  - CHS mode: the engine divides the block by heads x sectors, two quotient
//    bits per cycle, then divides the remainder by sectors per track for the
//    head number.
//  - The front register and job queue keep taking requests while the engine
//    divides, and the result register lets the engine move on while a
//    finished result waits for pop.
//  - A stalled consumer fills result register, queue and front register in
//    turn; full then rises. Nothing is dropped.
//  - Reset empties every stage and loads the config defaults
//    (prefix 0xA0, 16 heads, 63 sectors per track, precomp 0).
`include "ata_task_file_builder_unit_defines.svh"

module ata_task_file_builder_unit
    import atfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [27:0] start_block,
    input  logic [8:0]  sector_count,
    input  logic        is_write,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  precomp_byte,
    output logic [7:0]  count_byte,
    output logic [7:0]  sector_byte,
    output logic [7:0]  cyl_low_byte,
    output logic [7:0]  cyl_high_byte,
    output logic [7:0]  drive_head_byte,
    output logic [7:0]  command_byte,
    output logic [7:0]  control_byte,
    output logic        cylinder_overflow,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] ldh_prefix_reg;
    logic [4:0] head_count_reg;
    logic [7:0] spt_reg;
    logic [7:0] precomp_reg;
    cfg_t       cfg;
    logic       lba_mode;

    logic       q_push, q_full, q_pop, q_empty;
    job_t       q_in, q_out;
    result_t    res;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldh_prefix_reg <= LDH_RESET;
            head_count_reg <= HEADS_RESET;
            spt_reg        <= SPT_RESET;
            precomp_reg    <= PRECOMP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LDH:     ldh_prefix_reg <= cfg_data;
                REG_HEADS:   head_count_reg <= cfg_data[4:0];
                REG_SPT:     spt_reg        <= cfg_data;
                REG_WPCOM:   precomp_reg    <= cfg_data;
            endcase
        end
    end

    assign cfg.ldh     = ldh_prefix_reg;
    assign cfg.heads   = head_count_reg;
    assign cfg.spt     = spt_reg;
    assign cfg.precomp = precomp_reg;
    assign lba_mode    = ldh_prefix_reg[LDH_LBA_POS];

    // front end: one job register
    atfb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .start_block  (start_block),
        .sector_count (sector_count),
        .is_write     (is_write),
        .cfg          (cfg),
        .q_push       (q_push),
        .q_full       (q_full),
        .q_data       (q_in)
    );

    // decoupling queue
    atfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .full     (q_full),
        .data_in  (q_in),
        .pop      (q_pop),
        .empty    (q_empty),
        .data_out (q_out)
    );

    // conversion engine and result register
    atfb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign precomp_byte      = res.precomp;
    assign count_byte        = res.count;
    assign sector_byte       = res.sector;
    assign cyl_low_byte      = res.cyl_low;
    assign cyl_high_byte     = res.cyl_high;
    assign drive_head_byte   = res.drive_head;
    assign command_byte      = res.command;
    assign control_byte      = res.control;
    assign cylinder_overflow = res.overflow;

    // LBA results never flag a cylinder overflow
    `ATFB_ASSERT_NEVER(a_lba_no_ovf, !empty && cylinder_overflow && lba_mode)
    // CHS sector numbers are one-based and below 256
    `ATFB_ASSERT_NEVER(a_chs_sector_nonzero, !empty && !lba_mode && (sector_byte == 8'd0))
    // only read or write commands are built
    `ATFB_ASSERT_NEVER(a_cmd_code, !empty && (command_byte != OPC_READ_SECTORS) && (command_byte != OPC_WRITE_SECTORS))
    // a full front end always has a job waiting behind a full queue
    `ATFB_ASSERT_NEXT(a_full_holds, full && !q_pop, full)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ATA task-file builder unit.
`timescale 1ns / 100ps

module testbench
    import atfb_pkg::*;
();

    // Run bounds. The cycle limit is sized for the slowest legal run: about 520
    // requests with worst-case gaps and stalls, plus the long hold-off. The
    // limit leaves plenty of headroom.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 40;
    localparam logic [7:0] LBA_BIT = 8'(1 << LDH_LBA_POS);

    // One disk request as the sender offers it.
    typedef struct packed {
        logic [27:0] block;
        logic [8:0]  count;
        logic        wr;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [27:0] start_block;
    logic [8:0]  sector_count;
    logic        is_write;
    logic        empty;
    logic        pop;
    logic [7:0]  precomp_byte;
    logic [7:0]  count_byte;
    logic [7:0]  sector_byte;
    logic [7:0]  cyl_low_byte;
    logic [7:0]  cyl_high_byte;
    logic [7:0]  drive_head_byte;
    logic [7:0]  command_byte;
    logic [7:0]  control_byte;
    logic        cylinder_overflow;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Our copy of the drive geometry registers, kept in step with each write.
    cfg_t        disk_cfg;
    // Task files we expect, oldest first.
    result_t     expected_task_files[$];
    int          mismatch_count;
    int          cycle_count;
    // Random idling on both sides; cleared for the final stretch of traffic.
    bit          gaps_enabled;
    // Set by a test to make the sink hold pop low for that many cycles.
    int          sink_hold_cycles;

    ata_task_file_builder_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .start_block       (start_block),
        .sector_count      (sector_count),
        .is_write          (is_write),
        .empty             (empty),
        .pop               (pop),
        .precomp_byte      (precomp_byte),
        .count_byte        (count_byte),
        .sector_byte       (sector_byte),
        .cyl_low_byte      (cyl_low_byte),
        .cyl_high_byte     (cyl_high_byte),
        .drive_head_byte   (drive_head_byte),
        .command_byte      (command_byte),
        .control_byte      (control_byte),
        .cylinder_overflow (cylinder_overflow),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Predicted task file for one request under the current register values.
    // LBA mode spreads the 28-bit block over the address bytes; CHS mode
    // divides by heads x sectors per track, with a zero head count or zero
    // sectors per track treated as one. Only the low nibble of the head
    // lands in the drive/head byte, so head counts above sixteen wrap there.
    function automatic result_t build_task_file(input request_t req);
        result_t     tf;
        int unsigned heads;
        int unsigned spt;
        int unsigned per_cyl;
        int unsigned cyl;
        int unsigned head;
        int unsigned sec;
        tf.precomp  = disk_cfg.precomp;
        tf.count    = req.count[7:0];          // 256 and 0 both go out as 0
        tf.command  = req.wr ? OPC_WRITE_SECTORS : OPC_READ_SECTORS;
        tf.control  = (disk_cfg.heads >= HEADS_EIGHT) ? CTL_EIGHT : 8'h00;
        tf.overflow = 1'b0;
        if (disk_cfg.ldh[LDH_LBA_POS])
        begin
            tf.sector     = req.block[7:0];
            tf.cyl_low    = req.block[15:8];
            tf.cyl_high   = req.block[23:16];
            tf.drive_head = disk_cfg.ldh | {4'h0, req.block[27:24]};
        end
        else
        begin
            heads   = (disk_cfg.heads != 5'd0) ? 32'(disk_cfg.heads) : 32'd1;
            spt     = (disk_cfg.spt != 8'd0) ? 32'(disk_cfg.spt) : 32'd1;
            per_cyl = heads * spt;
            cyl     = 32'(req.block) / per_cyl;
            head    = (32'(req.block) % per_cyl) / spt;
            sec     = (32'(req.block) % spt) + 32'd1;
            tf.sector     = sec[7:0];
            tf.cyl_low    = cyl[7:0];
            tf.cyl_high   = cyl[15:8];
            tf.overflow   = (cyl > 32'hFFFF);
            tf.drive_head = disk_cfg.ldh | {4'h0, head[3:0]};
        end
        return tf;
    endfunction

    task automatic report_mismatch(input string note);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, note);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", field, got, want));
    endtask

    // Compare the task file leaving the block against the oldest prediction.
    task automatic check_task_file();
        result_t want;
        if (expected_task_files.size() == 0)
        begin
            report_mismatch("task file popped with no request outstanding");
            return;
        end
        want = expected_task_files.pop_front();
        check_field("precomp", precomp_byte, want.precomp);
        check_field("count", count_byte, want.count);
        check_field("sector", sector_byte, want.sector);
        check_field("cyl_low", cyl_low_byte, want.cyl_low);
        check_field("cyl_high", cyl_high_byte, want.cyl_high);
        check_field("drive_head", drive_head_byte, want.drive_head);
        check_field("command", command_byte, want.command);
        check_field("control", control_byte, want.control);
        check_field("overflow", {7'h0, cylinder_overflow}, {7'h0, want.overflow});
    endtask

    // Result side. Values read just after the edge are the pre-edge ones, so
    // a transfer is pop && !empty as seen here. Pop is then set for the next
    // edge: held low for a requested hold-off, for random stalls, else high.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_task_file();
            if (sink_hold_cycles > 0)
            begin
                sink_hold_cycles--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Offer one request and return at the edge where it transfers. Push stays
    // high on return so back-to-back requests follow without an idle gap; it is only
    // lowered for an idle gap or by settle_block.
    task automatic offer_request(input request_t req);
        int gap;
        gap = (gaps_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        start_block  <= req.block;
        sector_count <= req.count;
        is_write     <= req.wr;
        do
            @(posedge clk);
        while (full);
        expected_task_files.push_back(build_task_file(req));
    endtask

    task automatic offer(input logic [27:0] block, input logic [8:0] count,
                         input logic wr);
        request_t req;
        req.block = block;
        req.count = count;
        req.wr    = wr;
        offer_request(req);
    endtask

    // Stop offering and wait for every outstanding task file to come back.
    // Each request gives exactly one result, so the block is idle after this.
    task automatic settle_block();
        push <= 1'b0;
        while (expected_task_files.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_LDH:     disk_cfg.ldh     = value;
            REG_HEADS:   disk_cfg.heads   = value[4:0];
            REG_SPT:     disk_cfg.spt     = value;
            REG_WPCOM:   disk_cfg.precomp = value;
            default:     ;
        endcase
    endtask

    // Reprogram all four registers with the block idle.
    task automatic apply_setting(input logic [7:0] ldh, input logic [7:0] heads,
                                 input logic [7:0] spt, input logic [7:0] precomp);
        settle_block();
        write_register(REG_LDH, ldh);
        write_register(REG_HEADS, heads);
        write_register(REG_SPT, spt);
        write_register(REG_WPCOM, precomp);
        cfg_write <= 1'b0;
    endtask

    function automatic request_t random_request();
        request_t req;
        case ($urandom_range(0, 3))
            0:       req.block = 28'($urandom);
            1:       req.block = 28'($urandom_range(0, 20000));
            2:       req.block = 28'hFFF_FFFF - 28'($urandom_range(0, 4095));
            default: req.block = 28'($urandom_range(0, 1 << 20));
        endcase
        // Mostly legal counts, sometimes any 9-bit value (0 and above 256 too)
        req.count = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, 256));
        req.wr    = 1'($urandom_range(0, 1));
        return req;
    endfunction

    // Defaults after reset: CHS, 16 heads, 63 sectors, drive 0.
    // Covers count wrap (256 and 0 give 0), both commands and the overflow
    // flag at the top of the 28-bit range.
    task automatic test_reset_defaults();
        offer(28'd0, 9'd1, 1'b0);
        offer(28'd1007, 9'd256, 1'b1);
        offer(28'hFFF_FFFF, 9'd255, 1'b0);
        offer(28'd66_060_287, 9'd0, 1'b1);
        offer(28'd66_060_288, 9'd511, 1'b0);
        offer(28'h555_5555, 9'd257, 1'b1);
    endtask

    // LBA mode: address bytes taken straight from the block, never overflow.
    task automatic test_lba_mode();
        apply_setting(LDH_RESET | LBA_BIT | 8'h10, 8'd16, 8'd63, 8'hFF);
        offer(28'd0, 9'd1, 1'b1);
        offer(28'hFFF_FFFF, 9'd256, 1'b0);
        offer(28'hA5A_5A5A, 9'd128, 1'b1);
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'h00);
        offer(28'h5A5_A5A5, 9'd64, 1'b0);
    endtask

    // CHS corners: zero geometry treated as one, huge cylinders flagged,
    // head numbers above fifteen wrapped, control bit either side of eight.
    task automatic test_chs_corners();
        apply_setting(8'h00, 8'd0, 8'd0, 8'h80);
        offer(28'd65535, 9'd1, 1'b0);
        offer(28'd65536, 9'd2, 1'b1);
        offer(28'hFFF_FFFF, 9'd3, 1'b0);
        apply_setting(LDH_RESET, 8'd31, 8'd255, 8'h01);
        offer(28'd7904, 9'd4, 1'b1);
        offer(28'hFFF_FFFF, 9'd5, 1'b0);
        apply_setting(LDH_RESET | 8'h10, 8'd7, 8'd1, 8'hFF);
        offer(28'd13, 9'd6, 1'b1);
        apply_setting(LDH_RESET, 8'd8, 8'd1, 8'h7F);
        offer(28'd458_759, 9'd7, 1'b0);
        offer(28'd15, 9'd8, 1'b1);
    endtask

    // Long receiver hold-off while the sender keeps offering: the result
    // register, queue and front stage fill and full must rise with nothing lost.
    task automatic test_backpressure();
        apply_setting(LDH_RESET, 8'd16, 8'd63, 8'h22);
        gaps_enabled     = 1'b0;
        sink_hold_cycles = 300;
        repeat (12) offer_request(random_request());
        settle_block();
        apply_setting(LDH_RESET | LBA_BIT, 8'd4, 8'd17, 8'h33);
        sink_hold_cycles = 150;
        repeat (12) offer_request(random_request());
    endtask

    // Random traffic over a series of random register settings, extremes
    // included. Gaps come and go by phase; the final phase runs flat out.
    task automatic test_random_traffic();
        logic [7:0] ldh;
        logic [7:0] heads;
        logic [7:0] spt;
        logic [7:0] precomp;
        for (int phase = 0; phase < 8; phase++)
        begin
            ldh = 8'($urandom);
            case ($urandom_range(0, 6))
                0:       heads = 8'd0;
                1:       heads = 8'd1;
                2:       heads = 8'd31;
                3:       heads = 8'd8;
                4:       heads = 8'd7;
                default: heads = 8'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       spt = 8'd0;
                1:       spt = 8'd1;
                2:       spt = 8'd255;
                default: spt = 8'($urandom);
            endcase
            precomp = 8'($urandom);
            apply_setting(ldh, heads, spt, precomp);
            gaps_enabled = (phase < 7) && (phase % 3 != 2);
            repeat (60) offer_request(random_request());
        end
    endtask

    initial
    begin : test_sequence
        rst_n            <= 1'b0;
        push             <= 1'b0;
        start_block      <= '0;
        sector_count     <= '0;
        is_write         <= 1'b0;
        cfg_write        <= 1'b0;
        cfg_index        <= REG_LDH;
        cfg_data         <= '0;
        mismatch_count   = 0;
        sink_hold_cycles = 0;
        gaps_enabled     = 1'b1;
        disk_cfg = '{ldh: LDH_RESET, heads: HEADS_RESET, spt: SPT_RESET,
                     precomp: PRECOMP_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_lba_mode();
        test_chs_corners();
        test_backpressure();
        test_random_traffic();

        // Everything back, then a quiet spell to catch stray transfers
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_task_files.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
